FILE: sv/lcg_pkg.sv
`timescale 1ns / 1ps

package lcg_pkg;

    localparam int TERM_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 32;
    localparam int OUT_WIDTH      = 32;
    localparam int STATUS_WIDTH   = 2;
    localparam int MOD_WIDTH      = 33;
    localparam int RUN_WIDTH      = 32;
    localparam int CFG_IDX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH = 33;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SEED       = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MULTIPLIER = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_INCREMENT  = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS    = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_RUN_LENGTH = 3'd4;

    localparam logic [31:0]          RST_SEED       = 32'd1;
    localparam logic [31:0]          RST_MULTIPLIER = 32'd16807;
    localparam logic [31:0]          RST_INCREMENT  = 32'd0;
    localparam logic [MOD_WIDTH-1:0] RST_MODULUS    = 33'd2147483647;
    localparam logic [RUN_WIDTH-1:0] RST_RUN_LENGTH = 32'd1000;

    localparam logic [STATUS_WIDTH-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_WIDTH-1:0] ST_BAD_LEN  = 2'd1;
    localparam logic [STATUS_WIDTH-1:0] ST_FINISHED = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ADD,
        S_REM,
        S_FRAC,
        S_DONE
    } t_state;

endpackage

FILE: sv/lcg_req_if.sv
`timescale 1ns / 1ps

interface lcg_req_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink (input valid, input restart, output ready);
endinterface

FILE: sv/lcg_rsp_if.sv
`timescale 1ns / 1ps

interface lcg_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] term;
    logic [31:0] fraction;
    logic [1:0]  status;

    modport source (output valid, output term, output fraction, output status, input ready);
    modport sink (input valid, input term, input fraction, input status, output ready);
endinterface

FILE: sv/lcg_cfg_regs.sv
`timescale 1ns / 1ps

module lcg_cfg_regs import lcg_pkg::*; #(
    parameter int TERM_WIDTH = TERM_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    output logic [TERM_WIDTH-1:0]     o_seed,
    output logic [TERM_WIDTH-1:0]     o_mult,
    output logic [TERM_WIDTH-1:0]     o_inc,
    output logic [TERM_WIDTH:0]       o_mod,
    output logic [RUN_WIDTH-1:0]      o_run_len
);

    localparam logic [MOD_WIDTH-1:0] MOD_LIMIT = MOD_WIDTH'(1) << TERM_WIDTH;

    logic [TERM_WIDTH-1:0] r_seed;
    logic [TERM_WIDTH-1:0] r_mult;
    logic [TERM_WIDTH-1:0] r_inc;
    logic [MOD_WIDTH-1:0]  r_mod;
    logic [RUN_WIDTH-1:0]  r_run_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed    <= TERM_WIDTH'(RST_SEED);
            r_mult    <= TERM_WIDTH'(RST_MULTIPLIER);
            r_inc     <= TERM_WIDTH'(RST_INCREMENT);
            r_mod     <= RST_MODULUS;
            r_run_len <= RST_RUN_LENGTH;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SEED:       r_seed    <= i_cfg_data[TERM_WIDTH-1:0];
                CFG_MULTIPLIER: r_mult    <= i_cfg_data[TERM_WIDTH-1:0];
                CFG_INCREMENT:  r_inc     <= i_cfg_data[TERM_WIDTH-1:0];
                CFG_MODULUS:    r_mod     <= i_cfg_data[MOD_WIDTH-1:0];
                CFG_RUN_LENGTH: r_run_len <= i_cfg_data[RUN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // clamp the modulus so every term fits the term width
    assign o_mod     = (r_mod > MOD_LIMIT) ? MOD_LIMIT[TERM_WIDTH:0] : r_mod[TERM_WIDTH:0];
    assign o_seed    = r_seed;
    assign o_mult    = r_mult;
    assign o_inc     = r_inc;
    assign o_run_len = r_run_len;

endmodule

FILE: sv/lcg_div_step.sv
`timescale 1ns / 1ps

module lcg_div_step import lcg_pkg::*; #(
    parameter int TERM_WIDTH = TERM_WIDTH_DEF
) (
    input  logic [TERM_WIDTH-1:0] i_part,
    input  logic                  i_bit,
    input  logic [TERM_WIDTH:0]   i_mod,
    output logic [TERM_WIDTH-1:0] o_part,
    output logic                  o_q
);

    logic [TERM_WIDTH:0] shifted;
    logic [TERM_WIDTH:0] diff;

    always_comb begin
        shifted = {i_part, i_bit};
        diff    = shifted - i_mod;
        o_q     = (shifted >= i_mod);
        o_part  = o_q ? diff[TERM_WIDTH-1:0] : shifted[TERM_WIDTH-1:0];
    end

endmodule

FILE: sv/linear_congruential_generator.sv
`timescale 1ns / 1ps

// Linear congruential generator, one term per request beat.
// i_req carries a restart bit; on acceptance with restart high the seed is
// loaded and the run position cleared before the term is produced.
// o_rsp carries the term, its fraction term/modulus in Q0.32 and a status
// (ok, run length not below modulus, run finished; term and fraction are
// zero unless ok). Configuration is a write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): seed, multiplier, increment, modulus, run length.
// Timing: one request at a time. An ok request goes from acceptance to
// o_rsp.valid through the check and the multiply, then the increment,
// then 2*TERM_WIDTH steps of the shared restoring divide step for the
// remainder and 32 more of the same step for the fraction, then the load
// of the output register. A refused or finished request goes from the
// check straight to that load. i_req.ready is high only while idle, so a
// new request is accepted only after the last result has been loaded
// into the output register. The result waits in the output register while
// o_rsp.ready is low; the next request is accepted meanwhile, and its result
// waits for the register to be freed. Synchronous reset clears the term and
// position to zero (no seed load until a restart) and sets the register values.

module linear_congruential_generator import lcg_pkg::*; #(
    parameter int TERM_WIDTH = TERM_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lcg_req_if.sink                   i_req,
    lcg_rsp_if.source                 o_rsp,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data
);

    localparam int PW      = 2 * TERM_WIDTH;
    localparam int CNT_MAX = (PW > FRAC_BITS) ? PW : FRAC_BITS;
    localparam int CNT_W   = $clog2(CNT_MAX);

    logic [TERM_WIDTH-1:0] cfg_seed;
    logic [TERM_WIDTH-1:0] cfg_mult;
    logic [TERM_WIDTH-1:0] cfg_inc;
    logic [TERM_WIDTH:0]   cfg_mod;
    logic [RUN_WIDTH-1:0]  cfg_run_len;

    t_state                  r_state,  n_state;
    logic [TERM_WIDTH-1:0]   r_cur,    n_cur;
    logic [RUN_WIDTH-1:0]    r_pos,    n_pos;
    logic [PW-1:0]           r_dvd,    n_dvd;
    logic [TERM_WIDTH-1:0]   r_part,   n_part;
    logic [CNT_W-1:0]        r_cnt,    n_cnt;
    logic [FRAC_BITS-1:0]    r_frac,   n_frac;
    logic [STATUS_WIDTH-1:0] r_status, n_status;
    logic                    r_ovalid, n_ovalid;
    logic [OUT_WIDTH-1:0]    r_oterm,  n_oterm;
    logic [OUT_WIDTH-1:0]    r_ofrac,  n_ofrac;
    logic [STATUS_WIDTH-1:0] r_ostat,  n_ostat;

    logic                  step_bit;
    logic [TERM_WIDTH-1:0] step_part;
    logic                  step_q;
    logic                  bad_len;

    lcg_cfg_regs #(
        .TERM_WIDTH (TERM_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_seed     (cfg_seed),
        .o_mult     (cfg_mult),
        .o_inc      (cfg_inc),
        .o_mod      (cfg_mod),
        .o_run_len  (cfg_run_len)
    );

    assign step_bit = (r_state == S_REM) ? r_dvd[PW-1] : 1'b0;

    lcg_div_step #(
        .TERM_WIDTH (TERM_WIDTH)
    ) u_step (
        .i_part (r_part),
        .i_bit  (step_bit),
        .i_mod  (cfg_mod),
        .o_part (step_part),
        .o_q    (step_q)
    );

    assign bad_len = ({1'b0, cfg_run_len} >= MOD_WIDTH'(cfg_mod));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cur    <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cur    <= n_cur;
            r_pos    <= n_pos;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd    <= n_dvd;
        r_part   <= n_part;
        r_cnt    <= n_cnt;
        r_frac   <= n_frac;
        r_status <= n_status;
        r_oterm  <= n_oterm;
        r_ofrac  <= n_ofrac;
        r_ostat  <= n_ostat;
    end

    always_comb begin
        n_state  = r_state;
        n_cur    = r_cur;
        n_pos    = r_pos;
        n_dvd    = r_dvd;
        n_part   = r_part;
        n_cnt    = r_cnt;
        n_frac   = r_frac;
        n_status = r_status;
        n_ovalid = r_ovalid;
        n_oterm  = r_oterm;
        n_ofrac  = r_ofrac;
        n_ostat  = r_ostat;

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.restart) begin
                        n_cur = cfg_seed;
                        n_pos = '0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_dvd = PW'(cfg_mult) * PW'(r_cur);
                priority if (bad_len) begin
                    n_status = ST_BAD_LEN;
                    n_state  = S_DONE;
                end else if (r_pos >= cfg_run_len) begin
                    n_status = ST_FINISHED;
                    n_state  = S_DONE;
                end else begin
                    n_status = ST_OK;
                    n_state  = S_ADD;
                end
            end
            S_ADD: begin
                n_dvd   = r_dvd + PW'(cfg_inc);
                n_part  = '0;
                n_cnt   = CNT_W'(PW - 1);
                n_state = S_REM;
            end
            S_REM: begin
                n_dvd  = r_dvd << 1;
                n_part = step_part;
                if (r_cnt == '0) begin
                    n_cur   = step_part;
                    n_pos   = r_pos + RUN_WIDTH'(1);
                    n_cnt   = CNT_W'(FRAC_BITS - 1);
                    n_state = S_FRAC;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_FRAC: begin
                n_part = step_part;
                n_frac = {r_frac[FRAC_BITS-2:0], step_q};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_oterm  = (r_status == ST_OK) ? OUT_WIDTH'(r_cur) : '0;
                    n_ofrac  = (r_status == ST_OK) ? r_frac : '0;
                    n_ostat  = r_status;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign i_req.ready    = (r_state == S_IDLE);
    assign o_rsp.valid    = r_ovalid;
    assign o_rsp.term     = r_oterm;
    assign o_rsp.fraction = r_ofrac;
    assign o_rsp.status   = r_ostat;

`ifndef SYNTHESIS
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state == S_CHECK))
        else $error("accepted beat did not start a check");

    a_rem_to_frac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REM && r_cnt == '0) |=> (r_state == S_FRAC))
        else $error("remainder phase did not hand over to fraction phase");

    a_part_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FRAC) |-> ({1'b0, r_part} < cfg_mod))
        else $error("partial remainder not below modulus");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ostat != ST_OK) |-> (r_oterm == '0 && r_ofrac == '0))
        else $error("refused beat carries a nonzero term or fraction");

    a_pending_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> (r_ovalid && $stable(r_oterm) && $stable(r_ostat)))
        else $error("pending result overwritten");
`endif

endmodule
